// File: rtl/wpfd_pkg.sv
// ----------------------------------------------------------------------------
// WAVE PCM format detector package
// Shared types, phase and reason codes, header ids and the PCM subformat GUID.
// ----------------------------------------------------------------------------
package wpfd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} item_t;

	typedef struct packed {
		logic       simple_pcm;
		logic [2:0] reason;
	} result_t;

	localparam logic [2:0] PH_RIFF = 3'd0;
	localparam logic [2:0] PH_CHDR = 3'd1;
	localparam logic [2:0] PH_SKIP = 3'd2;
	localparam logic [2:0] PH_FMT  = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	localparam logic [2:0] RSN_PCM       = 3'd0;
	localparam logic [2:0] RSN_EXT_PCM   = 3'd1;
	localparam logic [2:0] RSN_BAD_HDR   = 3'd2;
	localparam logic [2:0] RSN_NO_FMT    = 3'd3;
	localparam logic [2:0] RSN_OTHER_TAG = 3'd4;
	localparam logic [2:0] RSN_EXT_OTHER = 3'd5;

	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_FMT  = 32'h666D_7420;

	localparam logic [15:0] TAG_PCM  = 16'h0001;
	localparam logic [15:0] TAG_EXT  = 16'hFFFE;
	localparam logic [5:0]  GUID_OFS = 6'd24;
	localparam logic [5:0]  FMT_MAX  = 6'd40;

	localparam logic [5:0] RIFF_ID_END  = 6'd4;
	localparam logic [5:0] RIFF_HDR_END = 6'd12;
	localparam logic [5:0] CHDR_ID_END  = 6'd4;
	localparam logic [5:0] CHDR_END     = 6'd8;
	localparam logic [5:0] TAG_END      = 6'd2;

	function automatic logic [7:0] pcm_guid_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h01;
			4'd6:    b = 8'h10;
			4'd8:    b = 8'h80;
			4'd11:   b = 8'hAA;
			4'd13:   b = 8'h38;
			4'd14:   b = 8'h9B;
			4'd15:   b = 8'h71;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/wpfd_parse.sv
// ----------------------------------------------------------------------------
// WAVE PCM format detector parser
// Per-file parse state; consumes one byte per enable and flags the verdict.
// ----------------------------------------------------------------------------
module wpfd_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  wpfd_pkg::item_t   item,
	output logic           res_fire,
	output wpfd_pkg::result_t res
);
	import wpfd_pkg::*;

	logic [2:0]  phase_q,   phase_d;
	logic [5:0]  cnt_q,     cnt_d;
	logic [31:0] id_q,      id_d;
	logic [31:0] len_q,     len_d;
	logic [32:0] skip_q,    skip_d;
	logic [15:0] tag_q,     tag_d;
	logic        guid_ok_q, guid_ok_d;
	logic        done_q,    done_d;

	logic        emit;
	logic [2:0]  rsn;
	logic [7:0]  b;
	logic [5:0]  cnt_inc;
	logic [5:0]  tgt;
	logic [5:0]  len_tgt;
	logic [5:0]  guid_pos;
	logic [32:0] skip_dec;

	assign b        = item.data_byte;
	assign cnt_inc  = cnt_q + 6'd1;
	assign tgt      = (len_q < 32'(FMT_MAX)) ? len_q[5:0] : FMT_MAX;
	assign len_tgt  = (len_d < 32'(FMT_MAX)) ? len_d[5:0] : FMT_MAX;
	assign guid_pos = cnt_q - GUID_OFS;
	assign skip_dec = (skip_q != 33'd0) ? (skip_q - 33'd1) : skip_q;

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		id_d      = id_q;
		len_d     = len_q;
		skip_d    = skip_q;
		tag_d     = tag_q;
		guid_ok_d = guid_ok_q;
		done_d    = done_q;
		emit      = 1'b0;
		rsn       = RSN_PCM;

		if (!done_q) begin
			unique case (phase_q)
				PH_RIFF: begin
					id_d  = {id_q[23:0], b};
					cnt_d = cnt_inc;
					if (cnt_inc == RIFF_ID_END && id_d != ID_RIFF) begin
						emit = 1'b1;
						rsn  = RSN_BAD_HDR;
					end else if (cnt_inc == RIFF_HDR_END) begin
						if (id_d != ID_WAVE) begin
							emit = 1'b1;
							rsn  = RSN_BAD_HDR;
						end else begin
							phase_d = PH_CHDR;
							cnt_d   = 6'd0;
							id_d    = 32'd0;
						end
					end
				end
				PH_CHDR: begin
					if (cnt_q < CHDR_ID_END)
						id_d = {id_q[23:0], b};
					else begin
						case (cnt_q[1:0])
							2'd0:    len_d[7:0]   = len_q[7:0]   | b;
							2'd1:    len_d[15:8]  = len_q[15:8]  | b;
							2'd2:    len_d[23:16] = len_q[23:16] | b;
							default: len_d[31:24] = len_q[31:24] | b;
						endcase
					end
					cnt_d = cnt_inc;
					if (cnt_inc == CHDR_END) begin
						cnt_d = 6'd0;
						if (id_d == ID_FMT) begin
							tag_d     = 16'd0;
							guid_ok_d = 1'b1;
							if (len_tgt == 6'd0) begin
								emit = 1'b1;
								rsn  = RSN_NO_FMT;
							end else
								phase_d = PH_FMT;
						end else begin
							skip_d  = {1'b0, len_d} + {32'd0, len_d[0]};
							phase_d = (skip_d == 33'd0) ? PH_CHDR : PH_SKIP;
							id_d    = 32'd0;
							len_d   = 32'd0;
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_dec;
					if (skip_dec == 33'd0) begin
						phase_d = PH_CHDR;
						cnt_d   = 6'd0;
						id_d    = 32'd0;
						len_d   = 32'd0;
					end
				end
				PH_FMT: begin
					if (cnt_q == 6'd0)
						tag_d = {8'd0, b};
					else if (cnt_q == 6'd1)
						tag_d = {b, tag_q[7:0]};
					else if (cnt_q >= GUID_OFS && cnt_q < FMT_MAX) begin
						if (b != pcm_guid_byte(guid_pos[3:0]))
							guid_ok_d = 1'b0;
					end
					cnt_d = cnt_inc;
					if (cnt_inc == TAG_END) begin
						if (tag_d == TAG_PCM) begin
							emit = 1'b1;
							rsn  = RSN_PCM;
						end else if (tag_d != TAG_EXT) begin
							emit = 1'b1;
							rsn  = RSN_OTHER_TAG;
						end else if (tgt < FMT_MAX) begin
							emit = 1'b1;
							rsn  = RSN_NO_FMT;
						end
					end else if (cnt_inc >= tgt) begin
						emit = 1'b1;
						if (tgt < TAG_END)
							rsn = RSN_NO_FMT;
						else
							rsn = guid_ok_d ? RSN_EXT_PCM : RSN_EXT_OTHER;
					end
				end
				default: begin
				end
			endcase
			if (emit) begin
				done_d  = 1'b1;
				phase_d = PH_DONE;
			end
		end

		if (item.end_of_file) begin
			if (!done_q && !emit) begin
				emit = 1'b1;
				rsn  = (phase_d == PH_RIFF) ? RSN_BAD_HDR : RSN_NO_FMT;
			end
			phase_d   = PH_RIFF;
			cnt_d     = 6'd0;
			id_d      = 32'd0;
			len_d     = 32'd0;
			skip_d    = 33'd0;
			tag_d     = 16'd0;
			guid_ok_d = 1'b1;
			done_d    = 1'b0;
		end
	end

	assign res_fire       = en && emit;
	assign res.reason     = rsn;
	assign res.simple_pcm = (rsn == RSN_PCM) || (rsn == RSN_EXT_PCM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_RIFF;
			cnt_q     <= 6'd0;
			id_q      <= 32'd0;
			len_q     <= 32'd0;
			skip_q    <= 33'd0;
			tag_q     <= 16'd0;
			guid_ok_q <= 1'b1;
			done_q    <= 1'b0;
		end else if (en) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			id_q      <= id_d;
			len_q     <= len_d;
			skip_q    <= skip_d;
			tag_q     <= tag_d;
			guid_ok_q <= guid_ok_d;
			done_q    <= done_d;
		end
	end

endmodule

// File: rtl/wpfd_out_reg.sv
// ----------------------------------------------------------------------------
// WAVE PCM format detector result register
// Holds one verdict until the downstream transfer; frees itself when taken.
// ----------------------------------------------------------------------------
module wpfd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  wpfd_pkg::result_t res,
	output logic              free,
	output logic              result_valid,
	input  logic              result_stall,
	output wpfd_pkg::result_t result
);
	import wpfd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free         = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (free)
			valid_q <= load;
	end

	always_ff @(posedge clk) begin
		if (load && free)
			res_q <= res;
	end

endmodule

// File: rtl/wave_pcm_format_detector_top.sv
// ----------------------------------------------------------------------------
// WAVE PCM format detector
// Takes one file byte per transfer and returns one PCM verdict per file.
// ----------------------------------------------------------------------------
// Throughput is one byte per clock while no held verdict is stalled; a byte
// passes through the input register and the parse logic into the result
// register, which holds its verdict. The parse state updates once per byte,
// and the input stalls while a byte waits and a held verdict is stalled.
module wave_pcm_format_detector_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  wpfd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output wpfd_pkg::result_t result
);
	import wpfd_pkg::*;

	logic    item_valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    advance;
	logic    res_fire;
	result_t res;

	assign advance    = item_valid_s1 && out_free;
	assign item_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_valid_s1 <= 1'b0;
		else if (!item_stall)
			item_valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	wpfd_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.item     (item_s1),
		.res_fire (res_fire),
		.res      (res)
	);

	wpfd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_fire),
		.res          (res),
		.free         (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// WAVE PCM format detector testbench
// Streams whole RIFF/WAVE files one byte per transfer: a short directed set,
// then random files, mostly well formed with random chunks, fmt sizes, tags
// and subformat GUIDs, and some corrupt, truncated or noise files. A scoreboard
// tracks the parse and predicts each file's verdict, which is checked against
// every result transfer. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import wpfd_pkg::*;

	// PCM subformat GUID, first byte of the chunk in the top byte
	localparam logic [127:0] PCM_SUBTYPE = 128'h0100_0000_0000_1000_8000_00AA_0038_9B71;

	class verdict_board;
		result_t     verdicts_due[$];
		int          errors;
		logic [2:0]  phase;
		logic [5:0]  count;
		logic [31:0] hdr_id;
		logic [31:0] chunk_len;
		logic [32:0] skip_left;
		logic [15:0] tag;
		bit          guid_ok;
		bit          decided;

		function new();
			errors = 0;
			rearm();
		endfunction

		function void rearm();
			phase     = PH_RIFF;
			count     = '0;
			hdr_id    = '0;
			chunk_len = '0;
			skip_left = '0;
			tag       = '0;
			guid_ok   = 1'b1;
			decided   = 1'b0;
		endfunction

		function void give(logic [2:0] why);
			result_t r;
			r.simple_pcm = (why == RSN_PCM) || (why == RSN_EXT_PCM);
			r.reason     = why;
			verdicts_due.push_back(r);
			decided = 1'b1;
			phase   = PH_DONE;
		endfunction

		function void note_byte(item_t it);
			logic [7:0]  b;
			logic [31:0] tgt;
			int          k;
			b = it.data_byte;
			if (!decided) begin
				case (phase)
					PH_RIFF: begin
						hdr_id = {hdr_id[23:0], b};
						count  = count + 6'd1;
						if (count == RIFF_ID_END && hdr_id != ID_RIFF) begin
							give(RSN_BAD_HDR);
						end else if (count == RIFF_HDR_END) begin
							if (hdr_id != ID_WAVE) begin
								give(RSN_BAD_HDR);
							end else begin
								phase  = PH_CHDR;
								count  = '0;
								hdr_id = '0;
							end
						end
					end
					PH_CHDR: begin
						if (count < CHDR_ID_END)
							hdr_id = {hdr_id[23:0], b};
						else
							chunk_len = chunk_len | (32'(b) << (8 * (count - CHDR_ID_END)));
						count = count + 6'd1;
						if (count == CHDR_END) begin
							count = '0;
							if (hdr_id == ID_FMT) begin
								tag     = '0;
								guid_ok = 1'b1;
								if (chunk_len == 32'd0)
									give(RSN_NO_FMT);
								else
									phase = PH_FMT;
							end else begin
								skip_left = {1'b0, chunk_len} + 33'(chunk_len[0]);
								phase     = (skip_left == '0) ? PH_CHDR : PH_SKIP;
								hdr_id    = '0;
								chunk_len = '0;
							end
						end
					end
					PH_SKIP: begin
						if (skip_left != '0)
							skip_left = skip_left - 33'd1;
						if (skip_left == '0) begin
							phase     = PH_CHDR;
							count     = '0;
							hdr_id    = '0;
							chunk_len = '0;
						end
					end
					PH_FMT: begin
						tgt = (chunk_len < 32'(FMT_MAX)) ? chunk_len : 32'(FMT_MAX);
						if (count == 6'd0) begin
							tag = {8'h00, b};
						end else if (count == 6'd1) begin
							tag[15:8] = b;
						end else if (count >= GUID_OFS && count < FMT_MAX) begin
							k = int'(count - GUID_OFS);
							if (b != PCM_SUBTYPE[8 * (15 - k) +: 8])
								guid_ok = 1'b0;
						end
						count = count + 6'd1;
						if (count == TAG_END) begin
							if (tag == TAG_PCM)
								give(RSN_PCM);
							else if (tag != TAG_EXT)
								give(RSN_OTHER_TAG);
							else if (tgt < 32'(FMT_MAX))
								give(RSN_NO_FMT);
						end else if (32'(count) >= tgt) begin
							if (tgt < 32'(TAG_END))
								give(RSN_NO_FMT);
							else
								give(guid_ok ? RSN_EXT_PCM : RSN_EXT_OTHER);
						end
					end
					default: ;
				endcase
			end
			if (it.end_of_file) begin
				if (!decided)
					give((phase == PH_RIFF) ? RSN_BAD_HDR : RSN_NO_FMT);
				rearm();
			end
		endfunction

		function void check_verdict(result_t got);
			result_t want;
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t: verdict with none due: expected none, got simple_pcm=%0b reason=%0d",
					$time, got.simple_pcm, got.reason);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.simple_pcm !== want.simple_pcm) begin
				errors++;
				$display("%0t: simple_pcm mismatch: expected %0b, got %0b",
					$time, want.simple_pcm, got.simple_pcm);
			end
			if (got.reason !== want.reason) begin
				errors++;
				$display("%0t: reason mismatch: expected %0d, got %0d",
					$time, want.reason, got.reason);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	verdict_board board = new();
	logic [7:0]   wav[$];
	bit           calm = 1'b0;
	int           bytes_sent = 0;
	int           files_sent = 0;

	wave_pcm_format_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 31);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_verdict(result);
	end

	function automatic void put_id(input logic [31:0] id);
		wav.push_back(id[31:24]);
		wav.push_back(id[23:16]);
		wav.push_back(id[15:8]);
		wav.push_back(id[7:0]);
	endfunction

	function automatic void put_le32(input logic [31:0] v);
		wav.push_back(v[7:0]);
		wav.push_back(v[15:8]);
		wav.push_back(v[23:16]);
		wav.push_back(v[31:24]);
	endfunction

	function automatic void put_noise(input int n);
		for (int i = 0; i < n; i++)
			wav.push_back(8'($urandom));
	endfunction

	function automatic void put_header();
		put_id(ID_RIFF);
		put_le32($urandom);
		put_id(ID_WAVE);
	endfunction

	function automatic void put_chunk(input logic [31:0] id, input logic [31:0] len,
			input int body);
		put_id(id);
		put_le32(len);
		put_noise(body);
	endfunction

	// body longer than 48 is cut to 40 to 48 bytes, the detector stops reading at 40 anyway
	function automatic void put_fmt(input logic [31:0] size, input logic [15:0] ftag,
			input bit spoil);
		int body;
		int spot;
		body = (size > 32'd48) ? 40 + $urandom_range(0, 8) : int'(size);
		spot = 24 + $urandom_range(0, 15);
		put_id(ID_FMT);
		put_le32(size);
		for (int i = 0; i < body; i++) begin
			if (i == 0)
				wav.push_back(ftag[7:0]);
			else if (i == 1)
				wav.push_back(ftag[15:8]);
			else if (i >= 24 && i < 40)
				wav.push_back(PCM_SUBTYPE[8 * (39 - i) +: 8] ^
					((spoil && i == spot) ? 8'($urandom_range(1, 255)) : 8'h00));
			else
				wav.push_back(8'($urandom));
		end
	endfunction

	function automatic void trim_to(input int n);
		while (wav.size() > n)
			void'(wav.pop_back());
	endfunction

	function automatic void make_random_file();
		int          r;
		int          len;
		logic [31:0] id;
		logic [31:0] size;
		logic [15:0] ftag;
		r = $urandom_range(99);
		wav.delete();
		if (r < 8) begin
			put_noise($urandom_range(1, 30));
			return;
		end
		put_header();
		if (r < 16)
			wav[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
		repeat ($urandom_range(0, 3)) begin
			id = $urandom;
			if (id == ID_FMT)
				id = id ^ 32'd1;
			case ($urandom_range(0, 9)) inside
				[0:5]:   len = $urandom_range(0, 9);
				[6:8]:   len = $urandom_range(10, 40);
				default: len = -1;
			endcase
			if (len < 0)
				put_chunk(id, ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : $urandom, 3);
			else
				put_chunk(id, 32'(len), len + (len & 1));
		end
		if ($urandom_range(0, 9) != 0) begin
			case ($urandom_range(0, 11)) inside
				0:       size = 32'd0;
				1:       size = 32'd1;
				2:       size = 32'd2;
				3:       size = 32'd16;
				4:       size = 32'd18;
				5:       size = 32'd39;
				[6:8]:   size = 32'd40;
				9:       size = 32'd41;
				10:      size = $urandom_range(0, 64);
				default: size = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : $urandom;
			endcase
			case ($urandom_range(0, 9)) inside
				[0:1]:   ftag = TAG_PCM;
				[2:6]:   ftag = TAG_EXT;
				7:       ftag = 16'($urandom);
				8:       ftag = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
				default: ftag = TAG_EXT ^ 16'(1 << $urandom_range(0, 15));
			endcase
			put_fmt(size, ftag, $urandom_range(0, 3) == 0);
		end
		put_noise($urandom_range(0, 4));
		if ($urandom_range(0, 7) == 0)
			trim_to($urandom_range(1, wav.size()));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		item_t it;
		it.data_byte   = b;
		it.end_of_file = last;
		while (!calm && $urandom_range(99) < 31) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		board.note_byte(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file();
		for (int i = 0; i < wav.size(); i++)
			send_byte(wav[i], i == wav.size() - 1);
		files_sent++;
	endtask

	initial begin
		int spin;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short header, both byte extremes
		wav = '{8'h00};
		send_file();
		wav = '{8'hFF};
		send_file();
		// bad RIFF id, then bad WAVE id
		wav.delete(); put_id(32'h5249_4658); put_noise(2);
		send_file();
		wav.delete(); put_id(ID_RIFF); put_le32(32'hFFFF_FFFF); put_id(32'h5741_5646);
		send_file();
		// header only: no fmt
		wav.delete(); put_header();
		send_file();
		// empty and odd chunks skipped, then plain PCM
		wav.delete(); put_header(); put_chunk(32'h6461_7461, 0, 0);
		put_chunk(32'h4C49_5354, 3, 4); put_fmt(16, TAG_PCM, 0);
		send_file();
		// fmt sizes zero and one
		wav.delete(); put_header(); put_fmt(0, TAG_PCM, 0); put_noise(2);
		send_file();
		wav.delete(); put_header(); put_fmt(1, TAG_PCM, 0);
		send_file();
		// short extensible, extensible PCM, extensible not PCM, other tag
		wav.delete(); put_header(); put_fmt(18, TAG_EXT, 0);
		send_file();
		wav.delete(); put_header(); put_fmt(40, TAG_EXT, 0);
		send_file();
		wav.delete(); put_header(); put_fmt(40, TAG_EXT, 1);
		send_file();
		wav.delete(); put_header(); put_fmt(16, 16'hFFFF, 0);
		send_file();
		// huge skip and fmt body cut short
		wav.delete(); put_header(); put_chunk(32'h6461_7461, 32'hFFFF_FFFF, 5);
		send_file();
		wav.delete(); put_header(); put_fmt(40, TAG_EXT, 0); trim_to(50);
		send_file();

		while (bytes_sent < 1600) begin
			calm = (bytes_sent >= 600 && bytes_sent < 900);
			make_random_file();
			send_file();
		end
		calm = 1'b0;
		item_valid <= 1'b0;

		spin = 0;
		while (board.verdicts_due.size() != 0 && spin < 2000) begin
			@(posedge clk);
			spin++;
		end
		repeat (10) @(posedge clk);
		if (board.verdicts_due.size() != 0) begin
			board.errors++;
			$display("%0t: %0d verdicts expected but never transferred",
				$time, board.verdicts_due.size());
		end
		if (board.errors == 0)
			$display("** wave_pcm_format_detector_top: PASSED **");
		else
			$display("** wave_pcm_format_detector_top: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("** wave_pcm_format_detector_top: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
rtl/wpfd_pkg.sv
rtl/wpfd_parse.sv
rtl/wpfd_out_reg.sv
rtl/wave_pcm_format_detector_top.sv
verif/tb.sv
